// ----- src/socks5rp_pkg.sv -----
// ----------------------------------------------------------------------------
// socks5rp_pkg
// Types and constants shared by the SOCKS5 request parser.
// ----------------------------------------------------------------------------
package socks5rp_pkg;

	typedef enum logic [3:0] {
		PH_VER      = 4'd0,
		PH_CMD      = 4'd1,
		PH_RSV      = 4'd2,
		PH_ATYP     = 4'd3,
		PH_ADDR     = 4'd4,
		PH_PORT     = 4'd5,
		PH_DONE     = 4'd6,
		PH_BAD_VER  = 4'd7,
		PH_BAD_CMD  = 4'd8,
		PH_BAD_ATYP = 4'd9,
		PH_BAD_RSV  = 4'd10
	} phase_t;

	localparam logic [7:0] PROTO_VERSION = 8'd5;
	localparam logic [7:0] CMD_CONNECT   = 8'd1;
	localparam logic [7:0] RSV_VALUE     = 8'h00;
	localparam logic [7:0] AT_IPV4       = 8'd1;
	localparam logic [7:0] AT_DOMAIN     = 8'd3;
	localparam logic [7:0] AT_IPV6       = 8'd4;
	localparam logic [7:0] IPV4_LEN      = 8'd4;
	localparam logic [7:0] IPV6_LEN      = 8'd16;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       new_request;
	} req_t;

	typedef struct packed {
		logic [3:0]  parse_state;
		logic        finished;
		logic        failed;
		logic [7:0]  command_code;
		logic [7:0]  address_type;
		logic        addr_valid;
		logic [7:0]  addr_index;
		logic [7:0]  addr_byte;
		logic [7:0]  domain_length;
		logic [15:0] dest_port;
	} res_t;

endpackage

// ----- src/socks5_request_parser.sv -----
// Results are registered. Throughput: one request byte per cycle while the skid
// entry is empty; the byte state machine updates in the accept cycle, and a two-entry
// output buffer keeps intake running while a result waits.
// Reset: arst_n clears the parse state to the version phase and all captured fields
// to zero; the output buffer empties.
// ----------------------------------------------------------------------------
// socks5_request_parser
// Byte-at-a-time SOCKS5 request parser with version, command, reserved and
// address type checks, address byte passthrough and big-endian port capture.
// ----------------------------------------------------------------------------
module socks5_request_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                request_valid,
	output logic                request_stall,
	input  socks5rp_pkg::req_t  request,
	output logic                result_valid,
	input  logic                result_stall,
	output socks5rp_pkg::res_t  result
);
	import socks5rp_pkg::*;

	phase_t      phase_q;
	logic [7:0]  cmd_q;
	logic [7:0]  atyp_q;
	logic [7:0]  addr_count_q;
	logic [7:0]  name_len_q;
	logic [7:0]  port_high_q;
	logic        port_count_q;
	logic [15:0] port_q;

	// State as seen by this byte, after an optional restart.
	phase_t      cur_phase;
	logic [7:0]  cur_cmd;
	logic [7:0]  cur_atyp;
	logic [7:0]  cur_count;
	logic [7:0]  cur_name_len;
	logic [7:0]  cur_port_high;
	logic        cur_port_count;
	logic [15:0] cur_port;

	phase_t      nxt_phase;
	logic [7:0]  nxt_cmd;
	logic [7:0]  nxt_atyp;
	logic [7:0]  nxt_count;
	logic [7:0]  nxt_name_len;
	logic [7:0]  nxt_port_high;
	logic        nxt_port_count;
	logic [15:0] nxt_port;
	logic        av;
	logic [7:0]  ai;
	logic [7:0]  ab;
	logic [7:0]  count_inc;
	logic [7:0]  fixed_len;
	logic [7:0]  b;
	res_t        res_new;

	logic        accept;
	logic        take;
	logic        out_valid_q;
	logic        skid_valid_q;
	res_t        out_q;
	res_t        skid_q;

	assign b = request.data_byte;

	always_comb begin
		if (request.new_request) begin
			cur_phase      = PH_VER;
			cur_cmd        = '0;
			cur_atyp       = '0;
			cur_count      = '0;
			cur_name_len   = '0;
			cur_port_high  = '0;
			cur_port_count = 1'b0;
			cur_port       = '0;
		end else begin
			cur_phase      = phase_q;
			cur_cmd        = cmd_q;
			cur_atyp       = atyp_q;
			cur_count      = addr_count_q;
			cur_name_len   = name_len_q;
			cur_port_high  = port_high_q;
			cur_port_count = port_count_q;
			cur_port       = port_q;
		end
	end

	assign count_inc = cur_count + 8'd1;
	assign fixed_len = (cur_atyp == AT_IPV4) ? IPV4_LEN : IPV6_LEN;

	always_comb begin
		nxt_phase      = cur_phase;
		nxt_cmd        = cur_cmd;
		nxt_atyp       = cur_atyp;
		nxt_count      = cur_count;
		nxt_name_len   = cur_name_len;
		nxt_port_high  = cur_port_high;
		nxt_port_count = cur_port_count;
		nxt_port       = cur_port;
		av             = 1'b0;
		ai             = '0;
		ab             = '0;
		case (cur_phase)
			PH_VER: begin
				nxt_phase = (b == PROTO_VERSION) ? PH_CMD : PH_BAD_VER;
			end
			PH_CMD: begin
				nxt_cmd   = b;
				nxt_phase = (b == CMD_CONNECT) ? PH_RSV : PH_BAD_CMD;
			end
			PH_RSV: begin
				nxt_phase = (b == RSV_VALUE) ? PH_ATYP : PH_BAD_RSV;
			end
			PH_ATYP: begin
				nxt_atyp       = b;
				nxt_count      = '0;
				nxt_port_count = 1'b0;
				nxt_phase      = (b inside {AT_IPV4, AT_DOMAIN, AT_IPV6}) ? PH_ADDR : PH_BAD_ATYP;
			end
			PH_ADDR: begin
				if (cur_atyp == AT_IPV4 || cur_atyp == AT_IPV6) begin
					av        = 1'b1;
					ai        = cur_count;
					ab        = b;
					nxt_count = count_inc;
					if (count_inc >= fixed_len) begin
						nxt_phase = PH_PORT;
					end
				end else if (cur_atyp == AT_DOMAIN) begin
					if (cur_count == 8'd0) begin
						// The first byte of a domain address is its length.
						nxt_name_len = b;
						nxt_count    = 8'd1;
						if (b == 8'd0) begin
							nxt_phase = PH_PORT;
						end
					end else begin
						av = 1'b1;
						ai = cur_count - 8'd1;
						ab = b;
						if (cur_count >= cur_name_len) begin
							nxt_phase = PH_PORT;
						end else begin
							nxt_count = count_inc;
						end
					end
				end
			end
			PH_PORT: begin
				if (!cur_port_count) begin
					nxt_port_high  = b;
					nxt_port_count = 1'b1;
				end else begin
					nxt_port  = {cur_port_high, b};
					nxt_phase = PH_DONE;
				end
			end
			default: begin
				// Done and error states hold until a new request restarts parsing.
			end
		endcase
	end

	always_comb begin
		res_new.parse_state   = nxt_phase;
		res_new.finished      = (nxt_phase >= PH_DONE);
		res_new.failed        = (nxt_phase >= PH_BAD_VER);
		res_new.command_code  = nxt_cmd;
		res_new.address_type  = nxt_atyp;
		res_new.addr_valid    = av;
		res_new.addr_index    = ai;
		res_new.addr_byte     = ab;
		res_new.domain_length = nxt_name_len;
		res_new.dest_port     = nxt_port;
	end

	assign request_stall = skid_valid_q;
	assign accept        = request_valid && !skid_valid_q;
	assign take          = out_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_VER;
			cmd_q        <= '0;
			atyp_q       <= '0;
			addr_count_q <= '0;
			name_len_q   <= '0;
			port_high_q  <= '0;
			port_count_q <= 1'b0;
			port_q       <= '0;
		end else if (accept) begin
			phase_q      <= nxt_phase;
			cmd_q        <= nxt_cmd;
			atyp_q       <= nxt_atyp;
			addr_count_q <= nxt_count;
			name_len_q   <= nxt_name_len;
			port_high_q  <= nxt_port_high;
			port_count_q <= nxt_port_count;
			port_q       <= nxt_port;
		end
	end

	// The skid entry only fills when the output entry is held, so it always
	// carries the younger result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res_new;
			end
		end else if (accept) begin
			if (out_valid_q) begin
				skid_q <= res_new;
			end else begin
				out_q <= res_new;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ----- tb/socks5_request_parser_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// socks5_request_parser_checker
// Watches both channels of the SOCKS5 request parser and keeps its own copy
// of the byte state machine. Each accepted request byte queues the result it
// should produce. Each accepted result is compared field by field with the
// oldest queued one.
// ----------------------------------------------------------------------------
module socks5_request_parser_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               request_valid,
	input  logic               request_stall,
	input  socks5rp_pkg::req_t request,
	input  logic               result_valid,
	input  logic               result_stall,
	input  socks5rp_pkg::res_t result,
	output int                 fail_count,
	output int                 outstanding,
	output int                 checked
);
	import socks5rp_pkg::*;

	localparam int MAX_PRINTS = 20;

	// Shadow copy of the parser registers.
	phase_t     phase;
	logic [7:0] cmd_seen;
	logic [7:0] atyp_seen;
	logic [7:0] addr_pos;
	logic [7:0] name_len;
	logic [7:0] port_hi;
	logic       port_half;
	logic [15:0] port_word;

	res_t expected_results[$];

	function automatic void clear_parser();
		phase     = PH_VER;
		cmd_seen  = '0;
		atyp_seen = '0;
		addr_pos  = '0;
		name_len  = '0;
		port_hi   = '0;
		port_half = 1'b0;
		port_word = '0;
	endfunction

	function automatic res_t parse_request_byte(input req_t r);
		res_t       o;
		logic [7:0] b;
		logic [7:0] fixed_len;
		o = '0;
		b = r.data_byte;
		if (r.new_request)
			clear_parser();
		case (phase)
		PH_VER: begin
			phase = (b == PROTO_VERSION) ? PH_CMD : PH_BAD_VER;
		end
		PH_CMD: begin
			cmd_seen = b;
			phase = (b == CMD_CONNECT) ? PH_RSV : PH_BAD_CMD;
		end
		PH_RSV: begin
			phase = (b == RSV_VALUE) ? PH_ATYP : PH_BAD_RSV;
		end
		PH_ATYP: begin
			atyp_seen = b;
			addr_pos  = '0;
			port_half = 1'b0;
			if (b == AT_IPV4 || b == AT_DOMAIN || b == AT_IPV6)
				phase = PH_ADDR;
			else
				phase = PH_BAD_ATYP;
		end
		PH_ADDR: begin
			if (atyp_seen == AT_IPV4 || atyp_seen == AT_IPV6) begin
				fixed_len    = (atyp_seen == AT_IPV4) ? IPV4_LEN : IPV6_LEN;
				o.addr_valid = 1'b1;
				o.addr_index = addr_pos;
				o.addr_byte  = b;
				addr_pos     = addr_pos + 8'd1;
				if (addr_pos >= fixed_len)
					phase = PH_PORT;
			end else if (atyp_seen == AT_DOMAIN) begin
				// The first byte of a domain address is its length, not a name byte.
				if (addr_pos == 8'd0) begin
					name_len = b;
					addr_pos = 8'd1;
					if (b == 8'd0)
						phase = PH_PORT;
				end else begin
					o.addr_valid = 1'b1;
					o.addr_index = addr_pos - 8'd1;
					o.addr_byte  = b;
					if (addr_pos >= name_len)
						phase = PH_PORT;
					else
						addr_pos = addr_pos + 8'd1;
				end
			end
		end
		PH_PORT: begin
			if (!port_half) begin
				port_hi   = b;
				port_half = 1'b1;
			end else begin
				port_word = {port_hi, b};
				phase     = PH_DONE;
			end
		end
		default: begin
		end
		endcase
		o.parse_state   = phase;
		o.finished      = (phase >= PH_DONE);
		o.failed        = (phase >= PH_BAD_VER);
		o.command_code  = cmd_seen;
		o.address_type  = atyp_seen;
		o.domain_length = name_len;
		o.dest_port     = port_word;
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= MAX_PRINTS)
			$display("MISMATCH at %0t ns, result %0d: %s", $time, checked, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			clear_parser();
			expected_results.delete();
			fail_count = 0;
			checked    = 0;
			outstanding <= 0;
		end else begin
			// Results accepted now belong to earlier requests, so pop before push.
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result arrived with no request waiting");
				end else begin
					want = expected_results.pop_front();
					check_field("parse_state", 16'(result.parse_state),
						16'(want.parse_state));
					check_field("finished", 16'(result.finished), 16'(want.finished));
					check_field("failed", 16'(result.failed), 16'(want.failed));
					check_field("command_code", 16'(result.command_code),
						16'(want.command_code));
					check_field("address_type", 16'(result.address_type),
						16'(want.address_type));
					check_field("addr_valid", 16'(result.addr_valid),
						16'(want.addr_valid));
					check_field("addr_index", 16'(result.addr_index),
						16'(want.addr_index));
					check_field("addr_byte", 16'(result.addr_byte),
						16'(want.addr_byte));
					check_field("domain_length", 16'(result.domain_length),
						16'(want.domain_length));
					check_field("dest_port", result.dest_port, want.dest_port);
				end
				checked++;
			end
			if (request_valid && !request_stall)
				expected_results.push_back(parse_request_byte(request));
			outstanding <= expected_results.size();
		end
	end

endmodule

// ----- tb/socks5_request_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// socks5_request_parser_tb
// Drives SOCKS5 request bytes into the parser: a directed pass over IPv4, the
// zero-length domain and each rejection, then random requests with faults
// mixed in, under sender gaps, receiver stalls and one long receiver
// hold-off. A checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module socks5_request_parser_tb;
	import socks5rp_pkg::*;

	localparam int HALF_PERIOD = 2;
	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 64;
	localparam int PHASE_ITEMS = 190;

	typedef logic [7:0] byte_q_t[$];

	typedef enum int {
		FAULT_NONE,
		FAULT_VER,
		FAULT_CMD,
		FAULT_RSV,
		FAULT_ATYP,
		FAULT_CUT,
		FAULT_TAIL,
		FAULT_NOISE
	} fault_t;

	logic clk           = 1'b0;
	logic arst_n        = 1'b0;
	logic request_valid = 1'b0;
	logic request_stall;
	req_t request       = '0;
	logic result_valid;
	logic result_stall  = 1'b0;
	res_t result;

	int fail_count;
	int outstanding;
	int checked;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int holds_asked   = 0;
	int holds_served  = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	int  bytes_sent    = 0;
	int  request_count = 0;
	int  faulty_count  = 0;
	bit  long_domain_sent = 1'b0;

	always #(HALF_PERIOD) clk = ~clk;

	socks5_request_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_stall (request_stall),
		.request       (request),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result)
	);

	socks5_request_parser_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_stall (request_stall),
		.request       (request),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.checked       (checked)
	);

	// Receiver: random stalls, plus a long hold-off whenever one is asked for.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left    <= 0;
			holds_served <= 0;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_asked;
			hold_left    <= HOLD_CYCLES - 1;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((request_valid && !request_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("Timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_byte(input logic [7:0] value, input logic restart);
		while ($urandom_range(99) < send_idle_pct) begin
			request_valid <= 1'b0;
			@(posedge clk);
		end
		request_valid <= 1'b1;
		request       <= '{data_byte: value, new_request: restart};
		do
			@(posedge clk);
		while (request_stall);
		bytes_sent++;
	endtask

	task automatic send_bytes(input byte_q_t seq, input logic restart_first);
		foreach (seq[i])
			send_byte(seq[i], restart_first && (i == 0));
	endtask

	// One request with random content; most are well formed, some are broken.
	task automatic send_request();
		byte_q_t    seq;
		logic [7:0] atyp;
		logic [7:0] len;
		logic [7:0] b;
		int         pick;
		int         n;
		fault_t     fault;
		pick = $urandom_range(99);
		if (pick < 55)      fault = FAULT_NONE;
		else if (pick < 61) fault = FAULT_VER;
		else if (pick < 67) fault = FAULT_CMD;
		else if (pick < 73) fault = FAULT_RSV;
		else if (pick < 79) fault = FAULT_ATYP;
		else if (pick < 87) fault = FAULT_CUT;
		else if (pick < 93) fault = FAULT_TAIL;
		else                fault = FAULT_NOISE;
		request_count++;
		if (fault != FAULT_NONE)
			faulty_count++;

		if (fault == FAULT_NOISE) begin
			n = $urandom_range(1, 3);
			repeat (n)
				send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
		end else begin
			case ($urandom_range(2))
			0:       atyp = AT_IPV4;
			1:       atyp = AT_IPV6;
			default: atyp = AT_DOMAIN;
			endcase
			seq = '{PROTO_VERSION, CMD_CONNECT, RSV_VALUE, atyp};
			if (atyp == AT_DOMAIN) begin
				if (!long_domain_sent && $urandom_range(29) == 0) begin
					len = 8'd255;
					long_domain_sent = 1'b1;
				end else begin
					len = 8'($urandom_range(0, ($urandom_range(3) == 0) ? 40 : 8));
				end
				seq.push_back(len);
				n = int'(len);
			end else begin
				n = int'((atyp == AT_IPV4) ? IPV4_LEN : IPV6_LEN);
			end
			repeat (n)
				seq.push_back(8'($urandom_range(255)));
			seq.push_back(8'($urandom_range(255)));
			seq.push_back(8'($urandom_range(255)));

			case (fault)
			FAULT_VER: begin
				do b = 8'($urandom_range(255)); while (b == PROTO_VERSION);
				seq[0] = b;
			end
			FAULT_CMD: begin
				do b = 8'($urandom_range(255)); while (b == CMD_CONNECT);
				seq[1] = b;
			end
			FAULT_RSV: begin
				seq[2] = 8'($urandom_range(1, 255));
			end
			FAULT_ATYP: begin
				do
					b = 8'($urandom_range(255));
				while (b == AT_IPV4 || b == AT_DOMAIN || b == AT_IPV6);
				seq[3] = b;
			end
			FAULT_CUT: begin
				n = $urandom_range(1, seq.size() - 1);
				while (seq.size() > n)
					void'(seq.pop_back());
			end
			FAULT_TAIL: begin
				repeat ($urandom_range(1, 4))
					seq.push_back(8'($urandom_range(255)));
			end
			default: begin
			end
			endcase
			// Now and then a request starts without the restart flag.
			send_bytes(seq, $urandom_range(19) != 0);
		end
	endtask

	task automatic run_phase(input int idle_pct, input int stall, input int items);
		int stop_at;
		send_idle_pct = idle_pct;
		stall_pct    <= stall;
		stop_at       = bytes_sent + items;
		while (bytes_sent < stop_at)
			send_request();
	endtask

	initial begin
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: IPv4 with extreme address and port bytes, straight after reset.
		send_bytes('{PROTO_VERSION, CMD_CONNECT, RSV_VALUE, AT_IPV4,
			8'h00, 8'hFF, 8'h80, 8'h7F, 8'hFF, 8'hFF}, 1'b0);
		// Zero-length domain goes straight to the port.
		send_bytes('{PROTO_VERSION, CMD_CONNECT, RSV_VALUE, AT_DOMAIN,
			8'h00, 8'h00, 8'h00}, 1'b1);
		// Bad version, then a byte that the error state must absorb.
		send_bytes('{8'h00, PROTO_VERSION}, 1'b1);
		send_bytes('{PROTO_VERSION, 8'hFF}, 1'b1);
		send_bytes('{PROTO_VERSION, CMD_CONNECT, 8'h80}, 1'b1);
		send_bytes('{PROTO_VERSION, CMD_CONNECT, RSV_VALUE, 8'h02}, 1'b1);

		run_phase(0, 0, PHASE_ITEMS);
		run_phase(49, 0, PHASE_ITEMS);
		run_phase(0, 49, PHASE_ITEMS);
		run_phase(30, 30, PHASE_ITEMS);

		// The receiver holds off while requests keep coming, so the block backs up.
		holds_asked <= holds_asked + 1;
		run_phase(0, 0, 40);
		request_valid <= 1'b0;

		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (4)
			@(posedge clk);

		$display("Sent %0d request bytes in %0d requests (%0d broken or noisy); %0d results checked.",
			bytes_sent, request_count, faulty_count, checked);
		$display("Ran free, with sender gaps, receiver stalls, both, and a %0d-cycle hold-off.",
			HOLD_CYCLES);
		if (fail_count == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
